### rtl/core/vertex_project_to_viewport_unit_assert.svh
// assertion macros for the vertex projection unit
// used by modules that check their own pipeline invariants
`ifndef VERTEX_PROJECT_TO_VIEWPORT_UNIT_ASSERT_SVH
`define VERTEX_PROJECT_TO_VIEWPORT_UNIT_ASSERT_SVH

// same-cycle implication under reset
`define VPV_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("vpv assertion failed");

// next-cycle implication under reset
`define VPV_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("vpv assertion failed");

`endif

### rtl/core/vpv_pkg.sv
// shared types, constants and helpers for the vertex projection unit
// no dependencies
`default_nettype none
package vpv_pkg;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} vtx_in_t;

	typedef struct packed {
		logic signed [31:0] screen_x;
		logic signed [31:0] screen_y;
		logic signed [31:0] screen_depth;
		logic               behind_eye;
	} vtx_out_t;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROW3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VP_ORIGIN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_VP_FAR      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH_RANGE = 3'd6;

	localparam logic [63:0] ROW0_RESET = 64'h0000_0000_0000_1000;
	localparam logic [63:0] ROW1_RESET = 64'h0000_0000_1000_0000;
	localparam logic [63:0] ROW2_RESET = 64'h0000_1000_0000_0000;
	localparam logic [63:0] ROW3_RESET = 64'h1000_0000_0000_0000;

	// clip coordinates in Q.28
	localparam int CLIP_W = 50;
	localparam int DIV_STEPS = 31;

	localparam int XF_STAGES = 2;
	localparam int DIV_STAGES = DIV_STEPS + 2;
	localparam int MAP_STAGES = 2;
	localparam int LATENCY = XF_STAGES + DIV_STAGES + MAP_STAGES;

	typedef logic [3:0][63:0] matrix_t;

	typedef struct packed {
		logic [31:0] vp_origin;
		logic [31:0] vp_far;
		logic [31:0] depth_range;
	} vp_cfg_t;

	function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
		logic signed [31:0] r;
		if (v > 51'sd2147483647)
			r = 32'sh7FFF_FFFF;
		else if (v < -51'sd2147483648)
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage
`default_nettype wire

### rtl/core/vpv_xform.sv
// matrix transform stages: products, then row sums into clip coordinates
// depends on vpv_pkg
`default_nettype none
module vpv_xform (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	input  wire vpv_pkg::vtx_in_t                 vertex,
	input  wire vpv_pkg::matrix_t                 matrix,
	output logic                                  out_valid,
	output logic signed [vpv_pkg::CLIP_W-1:0]     clip [0:3]
);
	import vpv_pkg::*;

	logic               valid_s1;
	logic signed [47:0] prod_s1 [0:3][0:2];
	logic signed [15:0] wterm_s1 [0:3];
	logic               valid_s2;
	logic signed [CLIP_W-1:0] clip_s2 [0:3];

	logic signed [31:0] pos [0:2];
	assign pos[0] = vertex.pos_x;
	assign pos[1] = vertex.pos_y;
	assign pos[2] = vertex.pos_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 3; c++)
				prod_s1[r][c] <= $signed(matrix[r][16*c +: 16]) * pos[c];
			wterm_s1[r] <= $signed(matrix[r][48 +: 16]);
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 4; r++) begin
			clip_s2[r] <= CLIP_W'(prod_s1[r][0]) + CLIP_W'(prod_s1[r][1])
				+ CLIP_W'(prod_s1[r][2]) + {CLIP_W'(wterm_s1[r]) <<< 16};
		end
	end

	assign out_valid = valid_s2;
	assign clip = clip_s2;

endmodule
`default_nettype wire

### rtl/core/vpv_div.sv
// perspective divide: restoring divider, one quotient bit per stage, three lanes
// depends on vpv_pkg and the assertion header
`default_nettype none
`include "vertex_project_to_viewport_unit_assert.svh"
module vpv_div (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	input  wire logic signed [vpv_pkg::CLIP_W-1:0] clip [0:3],
	output logic                                  out_valid,
	output logic signed [31:0]                    nrm [0:2],
	output logic                                  behind
);
	import vpv_pkg::*;

	typedef struct packed {
		logic                 neg;
		logic                 ovf;
		logic [CLIP_W-1:0]    rem;
		logic [DIV_STEPS-1:0] nb;
		logic [DIV_STEPS-1:0] quo;
	} lane_t;

	logic              vld_s    [0:DIV_STEPS];
	logic              behind_s [0:DIV_STEPS];
	logic [CLIP_W-1:0] w_s      [0:DIV_STEPS];
	lane_t             lane_s   [0:DIV_STEPS][0:2];

	logic              vld_sf;
	logic              behind_sf;
	logic signed [31:0] nrm_sf [0:2];

	// operand prep
	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			logic [CLIP_W-1:0] mag;
			logic [CLIP_W-1:0] r0;
			mag = clip[l][CLIP_W-1] ? CLIP_W'(-clip[l]) : CLIP_W'(clip[l]);
			r0 = mag >> 15;
			lane_s[0][l].neg <= clip[l][CLIP_W-1];
			lane_s[0][l].ovf <= r0 >= CLIP_W'(clip[3]);
			lane_s[0][l].rem <= r0;
			lane_s[0][l].nb  <= {mag[14:0], 16'b0};
			lane_s[0][l].quo <= '0;
		end
		behind_s[0] <= clip[3] <= 0;
		w_s[0] <= CLIP_W'(clip[3]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_STEPS; k++)
				vld_s[k] <= 1'b0;
			vld_sf <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
			for (int k = 1; k <= DIV_STEPS; k++)
				vld_s[k] <= vld_s[k-1];
			vld_sf <= vld_s[DIV_STEPS];
		end
	end

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
		always_ff @(posedge clk) begin
			for (int l = 0; l < 3; l++) begin
				logic [CLIP_W:0] trial;
				logic            ge;
				trial = {lane_s[k-1][l].rem, lane_s[k-1][l].nb[DIV_STEPS-1]};
				ge = trial >= {1'b0, w_s[k-1]};
				lane_s[k][l].neg <= lane_s[k-1][l].neg;
				lane_s[k][l].ovf <= lane_s[k-1][l].ovf;
				lane_s[k][l].rem <= ge ? CLIP_W'(trial - {1'b0, w_s[k-1]})
					: CLIP_W'(trial);
				lane_s[k][l].nb  <= lane_s[k-1][l].nb << 1;
				lane_s[k][l].quo <= {lane_s[k-1][l].quo[DIV_STEPS-2:0], ge};
			end
			behind_s[k] <= behind_s[k-1];
			w_s[k] <= w_s[k-1];
		end
	end

	// sign, saturation and the behind-eye zero
	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			logic signed [31:0] q;
			q = $signed({1'b0, lane_s[DIV_STEPS][l].quo});
			if (behind_s[DIV_STEPS])
				nrm_sf[l] <= '0;
			else if (lane_s[DIV_STEPS][l].ovf)
				nrm_sf[l] <= lane_s[DIV_STEPS][l].neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			else
				nrm_sf[l] <= lane_s[DIV_STEPS][l].neg ? -q : q;
		end
		behind_sf <= behind_s[DIV_STEPS];
	end

	assign out_valid = vld_sf;
	assign nrm = nrm_sf;
	assign behind = behind_sf;

	`VPV_ASSERT_IMP(a_rem_x, clk, arst_n, vld_s[DIV_STEPS] && !behind_s[DIV_STEPS] && !lane_s[DIV_STEPS][0].ovf, lane_s[DIV_STEPS][0].rem < w_s[DIV_STEPS])
	`VPV_ASSERT_IMP(a_rem_y, clk, arst_n, vld_s[DIV_STEPS] && !behind_s[DIV_STEPS] && !lane_s[DIV_STEPS][1].ovf, lane_s[DIV_STEPS][1].rem < w_s[DIV_STEPS])
	`VPV_ASSERT_IMP(a_rem_z, clk, arst_n, vld_s[DIV_STEPS] && !behind_s[DIV_STEPS] && !lane_s[DIV_STEPS][2].ovf, lane_s[DIV_STEPS][2].rem < w_s[DIV_STEPS])

endmodule
`default_nettype wire

### rtl/core/vpv_map.sv
// viewport and depth mapping with saturation to Q16.16
// depends on vpv_pkg
`default_nettype none
module vpv_map (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic signed [31:0]  nrm [0:2],
	input  wire logic                behind,
	input  wire vpv_pkg::vp_cfg_t    vp_cfg,
	output logic                     out_valid,
	output vpv_pkg::vtx_out_t        result
);
	import vpv_pkg::*;

	logic               valid_s1;
	logic signed [49:0] px_s1;
	logic signed [49:0] py_s1;
	logic signed [48:0] pz_s1;
	logic               behind_s1;
	logic               valid_s2;
	vtx_out_t           res_s2;

	logic signed [16:0] left, bottom, width, height, dspan;
	logic [16:0]        dsum;

	assign left   = 17'($signed(vp_cfg.vp_origin[15:0]));
	assign bottom = 17'($signed(vp_cfg.vp_origin[31:16]));
	assign width  = 17'($signed(vp_cfg.vp_far[15:0])) - left;
	assign height = 17'($signed(vp_cfg.vp_far[31:16])) - bottom;
	assign dspan  = $signed({1'b0, vp_cfg.depth_range[31:16]})
		- $signed({1'b0, vp_cfg.depth_range[15:0]});
	assign dsum   = {1'b0, vp_cfg.depth_range[31:16]} + {1'b0, vp_cfg.depth_range[15:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		px_s1 <= width * ($signed(33'sd65536) + 33'(nrm[0]));
		py_s1 <= height * ($signed(33'sd65536) + 33'(nrm[1]));
		pz_s1 <= dspan * nrm[2];
		behind_s1 <= behind;
	end

	always_ff @(posedge clk) begin
		logic signed [50:0] tx, ty, tz;
		tx = (51'(left) <<< 16) + (51'(px_s1) >>> 1);
		ty = (51'(bottom) <<< 16) + (51'(py_s1) >>> 1);
		tz = (51'(pz_s1) + $signed({18'b0, dsum, 16'b0})) >>> 17;
		res_s2.screen_x     <= sat32(tx);
		res_s2.screen_y     <= sat32(ty);
		res_s2.screen_depth <= sat32(tz);
		res_s2.behind_eye   <= behind_s1;
	end

	assign out_valid = valid_s2;
	assign result = res_s2;

endmodule
`default_nettype wire

### rtl/core/vertex_project_to_viewport_unit.sv
// top level: configuration registers, transform, divide and viewport map pipeline
// depends on vpv_pkg, vpv_xform, vpv_div, vpv_map and the assertion header
//
// channel   direction  signals                            beat taken when
// vertex    in         start, vertex                      start && !busy
// result    out        done, result                       done (one cycle, no hold-off)
// config    in         cfg_we, cfg_index, cfg_wdata       cfg_we
//
// the pipeline runs transform, then divide, then map
// one vertex a cycle; the 31-stage restoring divider sets the depth
// busy is always low, there is no backpressure
// reset clears the valid bits and loads the identity matrix, zero viewport
`default_nettype none
`include "vertex_project_to_viewport_unit_assert.svh"
module vertex_project_to_viewport_unit (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire vpv_pkg::vtx_in_t                     vertex,
	output logic                                      done,
	output vpv_pkg::vtx_out_t                         result,
	input  wire logic                                 cfg_we,
	input  wire logic [vpv_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [vpv_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
	import vpv_pkg::*;

	matrix_t  matrix_q;
	vp_cfg_t  vp_cfg_q;

	logic               xf_valid;
	logic signed [CLIP_W-1:0] clip [0:3];
	logic               dv_valid;
	logic signed [31:0] nrm [0:2];
	logic               behind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_q[0] <= ROW0_RESET;
			matrix_q[1] <= ROW1_RESET;
			matrix_q[2] <= ROW2_RESET;
			matrix_q[3] <= ROW3_RESET;
			vp_cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MATRIX_ROW0: matrix_q[0] <= cfg_wdata;
				REG_MATRIX_ROW1: matrix_q[1] <= cfg_wdata;
				REG_MATRIX_ROW2: matrix_q[2] <= cfg_wdata;
				REG_MATRIX_ROW3: matrix_q[3] <= cfg_wdata;
				REG_VP_ORIGIN:   vp_cfg_q.vp_origin <= cfg_wdata[31:0];
				REG_VP_FAR:      vp_cfg_q.vp_far <= cfg_wdata[31:0];
				REG_DEPTH_RANGE: vp_cfg_q.depth_range <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	vpv_xform u_xform (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.vertex   (vertex),
		.matrix   (matrix_q),
		.out_valid(xf_valid),
		.clip     (clip)
	);

	vpv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (xf_valid),
		.clip     (clip),
		.out_valid(dv_valid),
		.nrm      (nrm),
		.behind   (behind)
	);

	vpv_map u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (dv_valid),
		.nrm      (nrm),
		.behind   (behind),
		.vp_cfg   (vp_cfg_q),
		.out_valid(done),
		.result   (result)
	);

	`VPV_ASSERT_IMP(a_done_follows_start, clk, arst_n, done, $past(start, LATENCY))

endmodule
`default_nettype wire
